@@ rtl/core/rscb_pkg.sv @@
// Shared types and constants for the rolling-sum chunk boundary core.
package rscb_pkg;

  localparam int unsigned MaxWindow = 64;
  localparam int unsigned MaxChunk  = 8192;

  localparam int unsigned PtrW    = $clog2(MaxWindow);
  localparam int unsigned WinW    = $clog2(MaxWindow + 1);
  localparam int unsigned PosW    = $clog2(MaxChunk + 1);
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 10;
  localparam int unsigned WinLenW = 7;
  localparam int unsigned MaskW   = 10;
  localparam int unsigned LenW    = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [WinLenW-1:0] WinLenRst = 7'd48;
  localparam logic [MaskW-1:0]   MaskRst   = 10'd859;
  localparam logic [MaskW-1:0]   TargetRst = 10'd330;

  localparam logic [CfgIdxW-1:0] CfgWindowLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMask      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTarget    = 2'd2;

  localparam logic [1:0] CauseNone  = 2'd0;
  localparam logic [1:0] CauseSum   = 2'd1;
  localparam logic [1:0] CauseLimit = 2'd2;
  localparam logic [1:0] CauseEnd   = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             stream_end;
  } in_beat_t;

  typedef struct packed {
    logic            chunk_end;
    logic [LenW-1:0] chunk_length;
    logic [1:0]      cut_cause;
  } out_beat_t;

  typedef struct packed {
    logic [WinW-1:0]  win;
    logic [MaskW-1:0] mask;
    logic [MaskW-1:0] target;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [PtrW-1:0]  waddr;
    logic [ByteW-1:0] wdata;
    logic [PtrW-1:0]  raddr;
  } win_port_t;

endpackage

@@ rtl/core/rscb_window_mem.sv @@
// Window byte ring: synchronous RAM, one write and one registered read per cycle.
module rscb_window_mem (
  input  logic                      clk_i,
  input  rscb_pkg::win_port_t       port_i,
  input  logic                      re_i,
  output logic [rscb_pkg::ByteW-1:0] rdata_o
);
  import rscb_pkg::*;

  logic [ByteW-1:0] mem_q [MaxWindow];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (port_i.we) begin
      mem_q[port_i.waddr] <= port_i.wdata;
    end
  end

  // forward a same-cycle write to the read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (port_i.we && (port_i.waddr == port_i.raddr)) begin
        rdata_q <= port_i.wdata;
      end else begin
        rdata_q <= mem_q[port_i.raddr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rscb_cut_unit.sv @@
// Window sum, chunk position and ring pointer update with boundary decision.
module rscb_cut_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rscb_pkg::cfg_t             cfg_i,
  input  logic                       valid_i,
  input  logic                       fire_i,
  input  rscb_pkg::in_beat_t         beat_i,
  input  logic [rscb_pkg::ByteW-1:0] old_byte_i,
  output rscb_pkg::out_beat_t        result_o,
  output rscb_pkg::win_port_t        port_o
);
  import rscb_pkg::*;

  logic [SumW-1:0] sum_q, sum_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PtrW-1:0] ptr_q, ptr_d;

  logic [PtrW-1:0] p_cur, p_nxt;
  logic [WinW-1:0] p_inc;
  logic            drop_old;
  logic [SumW-1:0] sx_new, sx_old, sum_new;
  logic [PosW-1:0] len;
  logic [1:0]      cause;

  always_comb begin
    p_cur = (WinW'(ptr_q) >= cfg_i.win) ? '0 : ptr_q;
    p_inc = WinW'(p_cur) + WinW'(1);
    p_nxt = (p_inc >= cfg_i.win) ? '0 : PtrW'(p_inc);

    drop_old = (pos_q >= PosW'(cfg_i.win));
    sx_new   = {{(SumW-ByteW){beat_i.data_byte[ByteW-1]}}, beat_i.data_byte};
    sx_old   = drop_old ? {{(SumW-ByteW){old_byte_i[ByteW-1]}}, old_byte_i} : '0;
    sum_new  = sum_q + sx_new - sx_old;

    len = pos_q + PosW'(1);

    if ((len >= PosW'(cfg_i.win)) && ((sum_new & cfg_i.mask) == cfg_i.target)) begin
      cause = CauseSum;
    end else if (len >= PosW'(MaxChunk)) begin
      cause = CauseLimit;
    end else if (beat_i.stream_end) begin
      cause = CauseEnd;
    end else begin
      cause = CauseNone;
    end
  end

  assign result_o.chunk_end    = (cause != CauseNone);
  assign result_o.chunk_length = LenW'(len);
  assign result_o.cut_cause    = cause;

  // read ahead assuming no cut; after a cut the old byte goes unused
  assign port_o.we    = fire_i;
  assign port_o.waddr = p_cur;
  assign port_o.wdata = beat_i.data_byte;
  assign port_o.raddr = valid_i ? p_nxt : p_cur;

  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    ptr_d = ptr_q;
    if (fire_i) begin
      if (cause != CauseNone) begin
        sum_d = '0;
        pos_d = '0;
        ptr_d = '0;
      end else begin
        sum_d = sum_new;
        pos_d = len;
        ptr_d = p_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      pos_q <= '0;
      ptr_q <= '0;
    end else begin
      sum_q <= sum_d;
      pos_q <= pos_d;
      ptr_q <= ptr_d;
    end
  end

endmodule

@@ rtl/core/rolling_sum_chunk_boundary_core.sv @@
// Top level of the rolling-sum content-defined chunk boundary core.
//
// Input channel: one stream byte per beat (data_byte, stream_end) on
// in_valid_i / in_stall_o. Output channel: one result beat per input beat
// (chunk_end, chunk_length, cut_cause) on out_valid_o / out_stall_i.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 window length, 1 boundary mask, 2 boundary target); write only when idle.
// An accepted byte is registered in the read stage, and its result is then
// registered in the output register. Throughput: one byte per cycle while
// the receiver does not stall; the window RAM read for the next byte is
// issued while the current byte updates the rolling sum, so a byte follows every cycle.
// Reset clears the sum, chunk position, ring pointer and both pipeline
// stages, and loads the default window length 48, mask 859 and target 330.
// The window RAM is not cleared; entries are used only after being written.
// When the receiver stalls, the result holds in the output register, one
// more byte waits in the read stage, then in_stall_o rises.
module rolling_sum_chunk_boundary_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rscb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rscb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rscb_pkg::in_beat_t             in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rscb_pkg::out_beat_t            out_beat_o
);
  import rscb_pkg::*;

  logic [WinLenW-1:0] win_len_q;
  logic [MaskW-1:0]   mask_q;
  logic [MaskW-1:0]   target_q;
  cfg_t               cfg;

  logic      s1_valid_q;
  in_beat_t  s1_beat_q;
  logic      out_valid_q;
  out_beat_t out_beat_q;

  logic             advance, in_fire;
  out_beat_t        result;
  win_port_t        port;
  logic [ByteW-1:0] old_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WinLenRst;
      mask_q    <= MaskRst;
      target_q  <= TargetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowLen: win_len_q <= cfg_wdata_i[WinLenW-1:0];
        CfgMask:      mask_q    <= cfg_wdata_i[MaskW-1:0];
        CfgTarget:    target_q  <= cfg_wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // clamp window length to 1..MaxWindow
  always_comb begin
    if (win_len_q == '0) begin
      cfg.win = WinW'(1);
    end else if (32'(win_len_q) > MaxWindow) begin
      cfg.win = WinW'(MaxWindow);
    end else begin
      cfg.win = WinW'(win_len_q);
    end
    cfg.mask   = mask_q;
    cfg.target = target_q;
  end

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_beat_q <= in_beat_i;
    end
    if (advance) begin
      out_beat_q <= result;
    end
  end

  rscb_cut_unit u_cut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (s1_valid_q),
    .fire_i     (advance),
    .beat_i     (s1_beat_q),
    .old_byte_i (old_byte),
    .result_o   (result),
    .port_o     (port)
  );

  rscb_window_mem u_mem (
    .clk_i   (clk_i),
    .port_i  (port),
    .re_i    (in_fire),
    .rdata_o (old_byte)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
